>>> hdl/tcp_pkg.sv
// Package for the text command parser: state type, keyword tables and helpers.
`timescale 1ns / 1ps

package tcp_pkg;

  localparam int unsigned BufferBytes = 64;
  localparam int unsigned TakenW      = $clog2(BufferBytes);
  localparam logic [TakenW-1:0] TakenLimit = TakenW'(BufferBytes - 1);

  localparam int unsigned NumDev = 4;
  localparam int unsigned NumAct = 8;
  localparam int unsigned WordW  = 80;  // up to ten characters per keyword

  // keywords right-justified, first character in the highest used byte
  localparam logic [WordW-1:0] DevWord [NumDev] = '{"LED", "BUZZER", "SEG", "CDS"};
  localparam logic [3:0]       DevLen  [NumDev] = '{4'd3, 4'd6, 4'd3, 4'd3};
  localparam logic [WordW-1:0] ActWord [NumAct] = '{
    "ON", "OFF", "BRIGHT", "READ", "DISPLAY", "CLEAR", "COUNTDOWN", "AUTO"};
  localparam logic [3:0]       ActLen  [NumAct] = '{
    4'd2, 4'd3, 4'd6, 4'd4, 4'd7, 4'd5, 4'd9, 4'd4};

  // action codes that need a value token
  localparam logic [3:0] ActBright    = 4'd3;
  localparam logic [3:0] ActDisplay   = 4'd5;
  localparam logic [3:0] ActCountdown = 4'd7;

  // value parse phase codes
  localparam logic [1:0] PhSkip   = 2'd0;
  localparam logic [1:0] PhDigits = 2'd1;
  localparam logic [1:0] PhDone   = 2'd2;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  localparam logic [31:0] MagLimit = 32'h8000_0000;
  localparam logic [31:0] PosMax   = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]        token_index;
    logic [3:0]        token_length;
    logic              inside_token;
    logic [NumDev-1:0] device_hits;
    logic [NumAct-1:0] action_hits;
    logic [31:0]       value_accum;
    logic              value_negative;
    logic [1:0]        value_phase;
    logic              value_seen;
    logic [TakenW-1:0] bytes_taken;
    logic              text_ended;
  } tcp_state_t;

  localparam tcp_state_t StateReset = '{
    token_index:    2'd0,
    token_length:   4'd0,
    inside_token:   1'b0,
    device_hits:    '1,
    action_hits:    '1,
    value_accum:    32'd0,
    value_negative: 1'b0,
    value_phase:    PhSkip,
    value_seen:     1'b0,
    bytes_taken:    '0,
    text_ended:     1'b0
  };

  // character at position pos of a right-justified keyword of length len
  function automatic logic [7:0] kw_char(input logic [WordW-1:0] w, input logic [3:0] len,
                                         input logic [3:0] pos);
    logic [3:0] k;
    logic [7:0] c;
    c = 8'd0;
    k = len - pos - 4'd1;
    if (pos < len) begin
      c = w[{k, 3'b000} +: 8];
    end
    return c;
  endfunction

  function automatic logic [NumDev-1:0] narrow_dev(input logic [NumDev-1:0] hits,
                                                   input logic [3:0] pos, input logic [7:0] b);
    logic [NumDev-1:0] h;
    h = hits;
    for (int i = 0; i < NumDev; i++) begin
      if (pos >= DevLen[i] || kw_char(DevWord[i], DevLen[i], pos) != b) begin
        h[i] = 1'b0;
      end
    end
    return h;
  endfunction

  function automatic logic [NumAct-1:0] narrow_act(input logic [NumAct-1:0] hits,
                                                   input logic [3:0] pos, input logic [7:0] b);
    logic [NumAct-1:0] h;
    h = hits;
    for (int i = 0; i < NumAct; i++) begin
      if (pos >= ActLen[i] || kw_char(ActWord[i], ActLen[i], pos) != b) begin
        h[i] = 1'b0;
      end
    end
    return h;
  endfunction

  // ends the current token: keyword length must match exactly
  function automatic tcp_state_t close_token(input tcp_state_t s);
    tcp_state_t r;
    r = s;
    if (s.inside_token) begin
      if (s.token_index == 2'd0) begin
        for (int i = 0; i < NumDev; i++) begin
          if (DevLen[i] != s.token_length) r.device_hits[i] = 1'b0;
        end
      end else if (s.token_index == 2'd1) begin
        for (int i = 0; i < NumAct; i++) begin
          if (ActLen[i] != s.token_length) r.action_hits[i] = 1'b0;
        end
      end
      if (s.token_index != 2'd3) r.token_index = s.token_index + 2'd1;
      r.inside_token = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> hdl/tcp_byte_step.sv
// Next parser state for one text byte.
`timescale 1ns / 1ps

module tcp_byte_step (
  input  tcp_pkg::tcp_state_t state_i,
  input  logic [7:0]          byte_i,
  output tcp_pkg::tcp_state_t state_o
);
  import tcp_pkg::*;

  logic        is_digit;
  logic [3:0]  digit;
  logic [35:0] mag_wide;
  logic [31:0] mag_next;
  logic [3:0]  pos;

  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign digit    = 4'(byte_i - ChZero);
  // accum * 10 + digit, saturated to 2^31
  assign mag_wide = ({4'd0, state_i.value_accum} << 3) + ({4'd0, state_i.value_accum} << 1)
                  + {32'd0, digit};
  assign mag_next = (mag_wide > {4'd0, MagLimit}) ? MagLimit : mag_wide[31:0];

  always_comb begin
    tcp_state_t s;
    logic [1:0] ph;
    s   = state_i;
    ph  = state_i.value_phase;
    pos = state_i.token_length;
    if (!state_i.text_ended && state_i.bytes_taken < TakenLimit) begin
      s.bytes_taken = state_i.bytes_taken + TakenW'(1);
      if (byte_i == 8'd0) begin
        s.text_ended = 1'b1;
      end else if (byte_i == ChSpace) begin
        s = close_token(s);
      end else begin
        if (!state_i.inside_token) begin
          s.inside_token = 1'b1;
          pos            = 4'd0;
          if (state_i.token_index == 2'd2) s.value_seen = 1'b1;
        end
        unique case (state_i.token_index)
          2'd0: s.device_hits = narrow_dev(state_i.device_hits, pos, byte_i);
          2'd1: s.action_hits = narrow_act(state_i.action_hits, pos, byte_i);
          2'd2: begin
            // atoi style: whitespace, sign, digits
            if (ph == PhSkip) begin
              if (byte_i >= ChTab && byte_i <= ChCr) begin
                ph = PhSkip;
              end else if (byte_i == ChPlus || byte_i == ChMinus) begin
                s.value_negative = (byte_i == ChMinus);
                ph               = PhDigits;
              end else begin
                ph = is_digit ? PhDigits : PhDone;
                if (is_digit) s.value_accum = mag_next;
              end
            end else if (ph == PhDigits) begin
              if (is_digit) s.value_accum = mag_next;
              else          ph = PhDone;
            end
            s.value_phase = ph;
          end
          default: ;
        endcase
        s.token_length = (pos == 4'd15) ? pos : pos + 4'd1;
      end
    end
    state_o = s;
  end

endmodule

>>> hdl/text_command_parser.sv
// Top level of the text command parser: stream ports, state and result registers.
`timescale 1ns / 1ps

// Takes a command text one byte per item on the slave stream (tlast marks the
// last byte of a command buffer) and gives one result item per buffer on the
// master stream. One byte is taken every cycle unless the input stalls: a byte
// lands in the input register, then the keyword match and the multiply-by-ten
// value accumulate update the parse state, and on the tlast byte the result
// register is loaded, so a result passes the input and the result register.
// The input stalls only while a finished result waits in the result register
// and the byte in the input register is itself a tlast byte. A zero byte ends
// the text and only the first 63 bytes count; tokens split on spaces. Result:
// status 0 accepted / 1 rejected, device 1 LED, 2 BUZZER, 3 SEG, 4 CDS; action
// 1 ON, 2 OFF, 3 BRIGHT, 4 READ, 5 DISPLAY, 6 CLEAR, 7 COUNTDOWN, 8 AUTO (0 is
// unknown for both); number is the signed value of the third token,
// saturated to 32 bits, or -1 when none was taken.
module text_command_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [0] status, [3:1] device, [7:4] action, [39:8] number
);
  import tcp_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  logic       advance;
  logic       out_free;

  tcp_state_t state_q, state_step, state_end;

  logic        out_valid_q;
  logic [39:0] out_data_q, out_data_d;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  tcp_byte_step u_step (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .state_o (state_step)
  );

  // a pending token closes at the end of the buffer
  assign state_end = close_token(state_step);

  always_comb begin
    logic        status;
    logic [2:0]  dev;
    logic [3:0]  act;
    logic [31:0] num;
    status = 1'b1;
    dev    = 3'd0;
    act    = 4'd0;
    num    = 32'hFFFF_FFFF;
    if (state_end.token_index >= 2'd2) begin
      for (int i = NumDev - 1; i >= 0; i--) begin
        if (state_end.device_hits[i]) dev = 3'(i + 1);
      end
      if (dev != 3'd0) begin
        for (int i = NumAct - 1; i >= 0; i--) begin
          if (state_end.action_hits[i]) act = 4'(i + 1);
        end
        if (act == ActBright || act == ActDisplay || act == ActCountdown) begin
          if (state_end.value_seen) begin
            status = 1'b0;
            if (state_end.value_negative) begin
              num = 32'd0 - state_end.value_accum;
            end else begin
              num = (state_end.value_accum > PosMax) ? PosMax : state_end.value_accum;
            end
          end
        end else if (act != 4'd0) begin
          status = 1'b0;
        end
      end
    end
    out_data_d = {num, act, dev, status};
  end

  // parse state: back to reset after each buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (advance) begin
      state_q <= in_last_q ? StateReset : state_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> m_axis_tvalid)
    else $error("result not presented after last byte");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> (state_q == StateReset))
    else $error("parse state not cleared after result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready && in_valid_q && in_last_q) |-> !advance)
    else $error("pending result would be overwritten");

  a_taken_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bytes_taken <= TakenLimit)
    else $error("byte count beyond buffer limit");

endmodule
